[rtl/gtq_pkg.sv]
// ============================================================================
// gtq_pkg
// Shared sizes, codes and memory port bundles for the grouped team queue.
// ============================================================================
package gtq_pkg;

    // table sizes, powers of two
    localparam int STUDENTS = 1024;
    localparam int CLASSES  = 256;
    localparam int NODES    = 1024;

    localparam int STU_W  = $clog2(STUDENTS);
    localparam int CLS_W  = $clog2(CLASSES);
    localparam int NODE_W = $clog2(NODES);
    localparam int FTOP_W = NODE_W + 1;
    localparam int OCNT_W = CLS_W + 1;

    // field widths
    localparam int OPC_W = 2;
    localparam int SID_W = 10;
    localparam int CID_W = 8;
    localparam int STS_W = 2;

    // init sweep covers the class map and the free stack together
    localparam int SWEEP_N = (STUDENTS > NODES) ? STUDENTS : NODES;
    localparam int SWP_W   = $clog2(SWEEP_N) + 1;

    localparam logic [OPC_W-1:0] OP_MAP = 2'd0;
    localparam logic [OPC_W-1:0] OP_ENQ = 2'd1;
    localparam logic [OPC_W-1:0] OP_DEQ = 2'd2;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                cmap_we;
        logic [STU_W-1:0]    cmap_waddr;
        logic [CLS_W-1:0]    cmap_wdata;
        logic [STU_W-1:0]    cmap_raddr;
        logic                free_we;
        logic [NODE_W-1:0]   free_waddr;
        logic [NODE_W-1:0]   free_wdata;
        logic [NODE_W-1:0]   free_raddr;
        logic                nstu_we;
        logic [NODE_W-1:0]   nstu_waddr;
        logic [SID_W-1:0]    nstu_wdata;
        logic [NODE_W-1:0]   nstu_raddr;
        logic                nlink_we;
        logic [NODE_W-1:0]   nlink_waddr;
        logic [NODE_W-1:0]   nlink_wdata;
        logic [NODE_W-1:0]   nlink_raddr;
        logic                grp_we;
        logic [CLS_W-1:0]    grp_waddr;
        logic [2*NODE_W-1:0] grp_wdata;
        logic [CLS_W-1:0]    grp_raddr;
        logic                ring_we;
        logic [CLS_W-1:0]    ring_waddr;
        logic [CLS_W-1:0]    ring_wdata;
        logic [CLS_W-1:0]    ring_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [CLS_W-1:0]    cmap_rdata;
        logic [NODE_W-1:0]   free_rdata;
        logic [SID_W-1:0]    nstu_rdata;
        logic [NODE_W-1:0]   nlink_rdata;
        logic [2*NODE_W-1:0] grp_rdata;
        logic [CLS_W-1:0]    ring_rdata;
    } mem_rsp_t;

    function automatic logic [STU_W-1:0] stu_idx(input logic [SID_W-1:0] sid);
        return STU_W'(sid);
    endfunction

    function automatic logic [CLS_W-1:0] cls_idx(input logic [CID_W-1:0] cid);
        return CLS_W'(cid);
    endfunction

endpackage

[rtl/gtq_if.sv]
// ============================================================================
// gtq_if
// Request and response channels of the grouped team queue.
// ============================================================================
interface gtq_req_if import gtq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [SID_W-1:0] student_id;
    logic [CID_W-1:0] class_id;

    modport source (output valid, output opcode, output student_id, output class_id,
                    input ready);
    modport sink   (input valid, input opcode, input student_id, input class_id,
                    output ready);
endinterface

interface gtq_rsp_if import gtq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SID_W-1:0] student_out;
    logic [STS_W-1:0] status;

    modport source (output valid, output student_out, output status, input ready);
    modport sink   (input valid, input student_out, input status, output ready);
endinterface

[rtl/grouped_team_queue.sv]
// ============================================================================
// grouped_team_queue
// Team queue: students queue behind members of their own class, classes are
// served in the order they opened.
//
//   channel  dir  word fields
//   -------  ---  ------------------------------
//   req      in   opcode, student_id, class_id
//   rsp      out  student_out, status
//
// After reset an init sweep clears the class map and fills the free stack;
// req.ready stays low until it ends.
// One request at a time: map, failed and unused requests pass S_RESP,
// enqueue S_ENQ1 and S_ENQ2, dequeue S_DEQ1 to S_DEQ3 (order ring, class
// table and node pool are read one after another).
// The response register lets the next word in while a response waits; a
// stalled rsp holds the sequencer in its last step.
// ============================================================================
module grouped_team_queue import gtq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    gtq_req_if.sink   req,
    gtq_rsp_if.source rsp
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    gtq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    gtq_mem u_mem (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

endmodule

[rtl/gtq_ram.sv]
// ============================================================================
// gtq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gtq_mem.sv]
// ============================================================================
// gtq_mem
// Storage of the queue: class map, free stack, node pool, class table and
// class order ring.
// ============================================================================
module gtq_mem import gtq_pkg::*; (
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    gtq_ram #(.WIDTH(CLS_W), .DEPTH(STUDENTS)) u_cmap (
        .clk   (clk),
        .we    (req.cmap_we),
        .waddr (req.cmap_waddr),
        .wdata (req.cmap_wdata),
        .raddr (req.cmap_raddr),
        .rdata (rsp.cmap_rdata)
    );

    gtq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_free (
        .clk   (clk),
        .we    (req.free_we),
        .waddr (req.free_waddr),
        .wdata (req.free_wdata),
        .raddr (req.free_raddr),
        .rdata (rsp.free_rdata)
    );

    gtq_ram #(.WIDTH(SID_W), .DEPTH(NODES)) u_nstu (
        .clk   (clk),
        .we    (req.nstu_we),
        .waddr (req.nstu_waddr),
        .wdata (req.nstu_wdata),
        .raddr (req.nstu_raddr),
        .rdata (rsp.nstu_rdata)
    );

    gtq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_nlink (
        .clk   (clk),
        .we    (req.nlink_we),
        .waddr (req.nlink_waddr),
        .wdata (req.nlink_wdata),
        .raddr (req.nlink_raddr),
        .rdata (rsp.nlink_rdata)
    );

    // head in the upper half, tail in the lower half
    gtq_ram #(.WIDTH(2*NODE_W), .DEPTH(CLASSES)) u_grp (
        .clk   (clk),
        .we    (req.grp_we),
        .waddr (req.grp_waddr),
        .wdata (req.grp_wdata),
        .raddr (req.grp_raddr),
        .rdata (rsp.grp_rdata)
    );

    gtq_ram #(.WIDTH(CLS_W), .DEPTH(CLASSES)) u_ring (
        .clk   (clk),
        .we    (req.ring_we),
        .waddr (req.ring_waddr),
        .wdata (req.ring_wdata),
        .raddr (req.ring_raddr),
        .rdata (rsp.ring_rdata)
    );

endmodule

[rtl/gtq_ctrl.sv]
// ============================================================================
// gtq_ctrl
// Sequencer of the grouped team queue: walks each request through its
// dependent memory reads, writes back and loads the response register.
// ============================================================================
module gtq_ctrl import gtq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    gtq_req_if.sink    req,
    gtq_rsp_if.source  rsp,
    output mem_req_t   mem_req,
    input  mem_rsp_t   mem_rsp
);

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ENQ1  = 8'b0000_0100,
        S_ENQ2  = 8'b0000_1000,
        S_DEQ1  = 8'b0001_0000,
        S_DEQ2  = 8'b0010_0000,
        S_DEQ3  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [SWP_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic [FTOP_W-1:0]   free_top_reg, free_top_next;
    logic [CLS_W-1:0]    order_head_reg, order_head_next;
    logic [CLS_W-1:0]    order_tail_reg, order_tail_next;
    logic [OCNT_W-1:0]   order_count_reg, order_count_next;
    logic [CLASSES-1:0]  present_reg, present_next;
    logic [SID_W-1:0]    sid_reg, sid_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   head_reg, head_next;
    logic [NODE_W-1:0]   tail_reg, tail_next;
    logic [STS_W-1:0]    pend_sts_reg, pend_sts_next;
    logic                out_valid_reg, out_valid_next;
    logic [SID_W-1:0]    out_student_reg, out_student_next;
    logic [STS_W-1:0]    out_status_reg, out_status_next;

    logic                accept;
    logic                slot_free;
    logic                load_out;
    logic [SID_W-1:0]    load_student;
    logic [STS_W-1:0]    load_status;
    logic [NODE_W-1:0]   grp_head;
    logic [NODE_W-1:0]   grp_tail;

    assign req.ready       = (state_reg == S_IDLE);
    assign accept          = req.valid && req.ready;
    assign slot_free       = !out_valid_reg || rsp.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.student_out = out_student_reg;
    assign rsp.status      = out_status_reg;
    assign grp_head        = mem_rsp.grp_rdata[2*NODE_W-1:NODE_W];
    assign grp_tail        = mem_rsp.grp_rdata[NODE_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        free_top_next    = free_top_reg;
        order_head_next  = order_head_reg;
        order_tail_next  = order_tail_reg;
        order_count_next = order_count_reg;
        present_next     = present_reg;
        sid_next         = sid_reg;
        cls_next         = cls_reg;
        node_next        = node_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        pend_sts_next    = pend_sts_reg;
        load_out         = 1'b0;
        load_student     = '0;
        load_status      = STS_OK;
        mem_req          = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_cnt_reg < SWP_W'(STUDENTS))
                begin
                    mem_req.cmap_we    = 1'b1;
                    mem_req.cmap_waddr = STU_W'(sweep_cnt_reg);
                end
                if (sweep_cnt_reg < SWP_W'(NODES))
                begin
                    mem_req.free_we    = 1'b1;
                    mem_req.free_waddr = NODE_W'(sweep_cnt_reg);
                    mem_req.free_wdata = NODE_W'(sweep_cnt_reg);
                end
                sweep_cnt_next = SWP_W'(sweep_cnt_reg + 1'b1);
                if (sweep_cnt_reg == SWP_W'(SWEEP_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    sid_next = req.student_id;
                    unique case (req.opcode)
                        OP_MAP:
                        begin
                            mem_req.cmap_we    = 1'b1;
                            mem_req.cmap_waddr = stu_idx(req.student_id);
                            mem_req.cmap_wdata = cls_idx(req.class_id);
                            pend_sts_next      = STS_OK;
                            state_next         = S_RESP;
                        end
                        OP_ENQ:
                        begin
                            if (free_top_reg == '0)
                            begin
                                pend_sts_next = STS_FULL;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                mem_req.cmap_raddr = stu_idx(req.student_id);
                                mem_req.free_raddr = NODE_W'(free_top_reg - 1'b1);
                                free_top_next      = FTOP_W'(free_top_reg - 1'b1);
                                state_next         = S_ENQ1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (order_count_reg == '0)
                            begin
                                pend_sts_next = STS_EMPTY;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                mem_req.ring_raddr = order_head_reg;
                                state_next         = S_DEQ1;
                            end
                        end
                        default:
                        begin
                            pend_sts_next = STS_OK;
                            state_next    = S_RESP;
                        end
                    endcase
                end
            end

            S_ENQ1:
            begin
                cls_next           = mem_rsp.cmap_rdata;
                node_next          = mem_rsp.free_rdata;
                mem_req.nstu_we    = 1'b1;
                mem_req.nstu_waddr = mem_rsp.free_rdata;
                mem_req.nstu_wdata = sid_reg;
                mem_req.grp_raddr  = mem_rsp.cmap_rdata;
                state_next         = S_ENQ2;
            end

            S_ENQ2:
            begin
                // keep the read address so the class entry survives a stall
                mem_req.grp_raddr = cls_reg;
                if (slot_free)
                begin
                    mem_req.grp_we    = 1'b1;
                    mem_req.grp_waddr = cls_reg;
                    if (present_reg[cls_reg])
                    begin
                        mem_req.nlink_we    = 1'b1;
                        mem_req.nlink_waddr = grp_tail;
                        mem_req.nlink_wdata = node_reg;
                        mem_req.grp_wdata   = {grp_head, node_reg};
                    end
                    else
                    begin
                        // class opens at the back of the order
                        mem_req.grp_wdata     = {node_reg, node_reg};
                        present_next[cls_reg] = 1'b1;
                        mem_req.ring_we       = 1'b1;
                        mem_req.ring_waddr    = order_tail_reg;
                        mem_req.ring_wdata    = cls_reg;
                        order_tail_next       = CLS_W'(order_tail_reg + 1'b1);
                        order_count_next      = OCNT_W'(order_count_reg + 1'b1);
                    end
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DEQ1:
            begin
                cls_next          = mem_rsp.ring_rdata;
                mem_req.grp_raddr = mem_rsp.ring_rdata;
                state_next        = S_DEQ2;
            end

            S_DEQ2:
            begin
                head_next           = grp_head;
                tail_next           = grp_tail;
                mem_req.nstu_raddr  = grp_head;
                mem_req.nlink_raddr = grp_head;
                state_next          = S_DEQ3;
            end

            S_DEQ3:
            begin
                mem_req.nstu_raddr  = head_reg;
                mem_req.nlink_raddr = head_reg;
                if (slot_free)
                begin
                    if (head_reg == tail_reg)
                    begin
                        // last member gone, class leaves the order
                        present_next[cls_reg] = 1'b0;
                        order_head_next       = CLS_W'(order_head_reg + 1'b1);
                        order_count_next      = OCNT_W'(order_count_reg - 1'b1);
                    end
                    else
                    begin
                        mem_req.grp_we    = 1'b1;
                        mem_req.grp_waddr = cls_reg;
                        mem_req.grp_wdata = {mem_rsp.nlink_rdata, tail_reg};
                    end
                    if (free_top_reg < FTOP_W'(NODES))
                    begin
                        mem_req.free_we    = 1'b1;
                        mem_req.free_waddr = NODE_W'(free_top_reg);
                        mem_req.free_wdata = head_reg;
                        free_top_next      = FTOP_W'(free_top_reg + 1'b1);
                    end
                    load_out     = 1'b1;
                    load_student = mem_rsp.nstu_rdata;
                    state_next   = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    load_out    = 1'b1;
                    load_status = pend_sts_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_SWEEP;
            end
        endcase

        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_student_next = load_student;
            out_status_next  = load_status;
        end
        else
        begin
            out_valid_next   = out_valid_reg && !rsp.ready;
            out_student_next = out_student_reg;
            out_status_next  = out_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            sweep_cnt_reg   <= '0;
            free_top_reg    <= FTOP_W'(NODES);
            order_head_reg  <= '0;
            order_tail_reg  <= '0;
            order_count_reg <= '0;
            present_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            free_top_reg    <= free_top_next;
            order_head_reg  <= order_head_next;
            order_tail_reg  <= order_tail_next;
            order_count_reg <= order_count_next;
            present_reg     <= present_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sid_reg         <= sid_next;
        cls_reg         <= cls_next;
        node_reg        <= node_next;
        head_reg        <= head_next;
        tail_reg        <= tail_next;
        pend_sts_reg    <= pend_sts_next;
        out_student_reg <= out_student_next;
        out_status_reg  <= out_status_next;
    end

endmodule

[rtl/gtq_checker.sv]
// ============================================================================
// gtq_checker
// Port-level checks of the grouped team queue.
// ============================================================================
module gtq_checker import gtq_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [SID_W-1:0] rsp_student,
    input logic [STS_W-1:0] rsp_status
);

    // words taken but not yet answered
    logic [1:0] pend_reg, pend_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = req_valid && req_ready;
    assign out_take = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_take && !out_take)
        begin
            pend_next = 2'(pend_reg + 1'b1);
        end
        else if (out_take && !in_take)
        begin
            pend_next = 2'(pend_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == STS_OK || rsp_status == STS_EMPTY ||
                       rsp_status == STS_FULL))
        else $error("illegal status code");

    a_fail_no_student: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STS_OK |-> rsp_student == '0)
        else $error("student returned with a failing status");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> pend_reg != 2'd2)
        else $error("request taken with one in work and one waiting");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_student) &&
                                    $stable(rsp_status))
        else $error("stalled response changed");

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_student (rsp.student_out),
    .rsp_status  (rsp.status)
);
